// ===== rtl/dual_stack_shared_buffer_unit_assert.svh =====
// assertion macros for the dual stack shared buffer unit
// no dependencies; included by the controller and datapath modules
`ifndef DUAL_STACK_SHARED_BUFFER_UNIT_ASSERT_SVH
`define DUAL_STACK_SHARED_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is high
`define DSSB_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dssb assertion failed");
// clocked check that also holds through reset
`define DSSB_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dssb assertion failed");
`else
`define DSSB_ASSERT_RST(label, clk, rst, prop)
`define DSSB_ASSERT(label, clk, prop)
`endif
`endif

// ===== rtl/dssb_pkg.sv =====
// shared types and constants for the dual stack shared buffer unit
// no dependencies
`default_nettype none

package dssb_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int SIZE_W        = 5;

  // command codes, codes above CMD_PEEK_UP leave both stacks and the buffer unchanged
  localparam logic [CMD_W-1:0] CMD_PUSH_LO = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_LO  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK_LO = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH_UP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_UP  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_UP = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture command and push word
    logic exec;       // update counts, write or read the buffer
    logic take_read;  // capture buffer read data as top value
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic peek_hit;   // current command is a peek of a non-empty stack
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dssb_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dssb_ctrl.sv =====
// command sequencer for the dual stack shared buffer unit
// depends on dssb_pkg and dual_stack_shared_buffer_unit_assert.svh
`default_nettype none
`include "dual_stack_shared_buffer_unit_assert.svh"

module dssb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output dssb_pkg::dp_cmd_t      dp_cmd,
  input  wire dssb_pkg::dp_stat_t dp_stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        dp_cmd.load = start;
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        if (dp_stat.peek_hit) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_READ: begin
        dp_cmd.take_read = 1'b1;
        state_next       = S_IDLE;
        done_next        = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  `DSSB_ASSERT_RST(a_accept_goes_busy, clk, rst, start && !busy |=> busy)
  `DSSB_ASSERT_RST(a_done_single_cycle, clk, rst, done |=> !done)
  `DSSB_ASSERT_RST(a_done_when_idle, clk, rst, done |-> !busy)
  `DSSB_ASSERT(a_no_done_after_reset, clk, rst |=> !done)

endmodule

`default_nettype wire

// ===== rtl/dssb_dpath.sv =====
// stack counts, shared buffer and result registers
// depends on dssb_pkg, dssb_ram and dual_stack_shared_buffer_unit_assert.svh
`default_nettype none
`include "dual_stack_shared_buffer_unit_assert.svh"

module dssb_dpath #(
  parameter int DEPTH = dssb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dssb_pkg::dp_cmd_t               dp_cmd,
  output dssb_pkg::dp_stat_t                   dp_stat,
  input  wire logic [dssb_pkg::CMD_W-1:0]      command,
  input  wire logic signed [dssb_pkg::WORD_W-1:0] push_value,
  output logic signed [dssb_pkg::WORD_W-1:0]   top_value,
  output logic [dssb_pkg::STATUS_W-1:0]        status,
  output logic [dssb_pkg::SIZE_W-1:0]          lower_size,
  output logic [dssb_pkg::SIZE_W-1:0]          upper_size,
  output logic                                 lower_empty,
  output logic                                 upper_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = dssb_pkg::SIZE_W;
  localparam int WW = dssb_pkg::WORD_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

  logic [dssb_pkg::CMD_W-1:0] cmd;
  logic [WW-1:0]              value;
  logic [CW-1:0]              lower_cnt;
  logic [CW-1:0]              upper_cnt;
  logic [CW:0]                cnt_sum;
  logic                       full;
  logic                       is_push_lo, is_pop_lo, is_peek_lo;
  logic                       is_push_up, is_pop_up, is_peek_up;
  logic                       underflow;
  logic [CW-1:0]              lo_peek_idx, up_push_idx, up_peek_idx;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [WW-1:0]              ram_rdata;
  logic [CW+SW-1:0]           lower_ext, upper_ext;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd   <= command;
      value <= push_value;
    end
  end

  assign is_push_lo = (cmd == dssb_pkg::CMD_PUSH_LO);
  assign is_pop_lo  = (cmd == dssb_pkg::CMD_POP_LO);
  assign is_peek_lo = (cmd == dssb_pkg::CMD_PEEK_LO);
  assign is_push_up = (cmd == dssb_pkg::CMD_PUSH_UP);
  assign is_pop_up  = (cmd == dssb_pkg::CMD_POP_UP);
  assign is_peek_up = (cmd == dssb_pkg::CMD_PEEK_UP);

  assign cnt_sum     = {1'b0, lower_cnt} + {1'b0, upper_cnt};
  assign full        = (cnt_sum >= DEPTH_S);
  assign lower_empty = (lower_cnt == '0);
  assign upper_empty = (upper_cnt == '0);
  assign underflow   = ((is_pop_lo || is_peek_lo) && lower_empty) ||
                       ((is_pop_up || is_peek_up) && upper_empty);

  assign dp_stat.peek_hit = (is_peek_lo && !lower_empty) || (is_peek_up && !upper_empty);

  // the upper stack grows down from the last entry
  assign lo_peek_idx = lower_cnt - CW'(1);
  assign up_push_idx = DEPTH_C - upper_cnt - CW'(1);
  assign up_peek_idx = DEPTH_C - upper_cnt;

  assign ram_we    = dp_cmd.exec && (is_push_lo || is_push_up) && !full;
  assign ram_waddr = is_push_lo ? lower_cnt[AW-1:0] : up_push_idx[AW-1:0];
  assign ram_raddr = is_peek_lo ? lo_peek_idx[AW-1:0] : up_peek_idx[AW-1:0];

  dssb_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (value),
    .re    (dp_cmd.exec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_cnt <= '0;
      upper_cnt <= '0;
    end else if (dp_cmd.exec) begin
      if (is_push_lo && !full) begin
        lower_cnt <= lower_cnt + CW'(1);
      end else if (is_pop_lo && !lower_empty) begin
        lower_cnt <= lower_cnt - CW'(1);
      end else if (is_push_up && !full) begin
        upper_cnt <= upper_cnt + CW'(1);
      end else if (is_pop_up && !upper_empty) begin
        upper_cnt <= upper_cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      if (underflow) begin
        top_value <= '1;
        status    <= dssb_pkg::ST_UNDERFLOW;
      end else if ((is_push_lo || is_push_up) && full) begin
        top_value <= '0;
        status    <= dssb_pkg::ST_OVERFLOW;
      end else begin
        top_value <= '0;
        status    <= dssb_pkg::ST_DONE;
      end
    end else if (dp_cmd.take_read) begin
      top_value <= ram_rdata;
    end
  end

  // sizes report the low bits of the counts
  assign lower_ext  = {{SW{1'b0}}, lower_cnt};
  assign upper_ext  = {{SW{1'b0}}, upper_cnt};
  assign lower_size = lower_ext[SW-1:0];
  assign upper_size = upper_ext[SW-1:0];

  `DSSB_ASSERT_RST(a_never_overfilled, clk, rst, cnt_sum <= DEPTH_S)
  `DSSB_ASSERT_RST(a_lower_moves_on_exec, clk, rst, lower_cnt != $past(lower_cnt) |-> $past(dp_cmd.exec))
  `DSSB_ASSERT_RST(a_upper_moves_on_exec, clk, rst, upper_cnt != $past(upper_cnt) |-> $past(dp_cmd.exec))

endmodule

`default_nettype wire

// ===== rtl/dual_stack_shared_buffer_unit.sv =====
// top level of the dual stack shared buffer unit: two stacks in one buffer
// depends on dssb_pkg, dssb_ctrl, dssb_dpath and dssb_ram
//
//  channel   | handshake      | payload
//  ----------+----------------+-----------------------------------------------
//  command   | start / busy   | command, push_value
//  result    | done (strobe)  | top_value, status, lower_size, upper_size,
//            |                | lower_empty, upper_empty
//
// a transaction is taken at a rising edge with start high and busy low
// push, pop and unused codes pass through the execute state only, and the
// result strobes in the cycle after the execute cycle
// successful peek: adds a read state for the registered read of the buffer ram
// reset (rst, synchronous) empties both stacks; the buffer itself is not cleared
// done is high for exactly one cycle and the result ports hold for that cycle;
// the receiver cannot stall
`default_nettype none

module dual_stack_shared_buffer_unit #(
  parameter int DEPTH = dssb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // command transaction
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [dssb_pkg::CMD_W-1:0]         command,
  input  wire logic signed [dssb_pkg::WORD_W-1:0] push_value,
  // result transaction
  output logic                                    done,
  output logic signed [dssb_pkg::WORD_W-1:0]      top_value,
  output logic [dssb_pkg::STATUS_W-1:0]           status,
  output logic [dssb_pkg::SIZE_W-1:0]             lower_size,
  output logic [dssb_pkg::SIZE_W-1:0]             upper_size,
  output logic                                    lower_empty,
  output logic                                    upper_empty
);

  // control between sequencer and datapath
  dssb_pkg::dp_cmd_t  dp_cmd;
  dssb_pkg::dp_stat_t dp_stat;

  // sequencer: idle, execute, optional read wait, and the result strobe
  dssb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .dp_cmd  (dp_cmd),
    .dp_stat (dp_stat)
  );

  // datapath: counts, shared buffer ram and result registers
  dssb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .command     (command),
    .push_value  (push_value),
    .top_value   (top_value),
    .status      (status),
    .lower_size  (lower_size),
    .upper_size  (upper_size),
    .lower_empty (lower_empty),
    .upper_empty (upper_empty)
  );

endmodule

`default_nettype wire
